>>> hw/rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// shared widths, defaults and register codes for the set-associative lookup
// ----------------------------------------------------------------------------
package sacl_pkg;

    // build defaults
    localparam int MAX_WAYS_DEF = 8;
    localparam int SETS_DEF     = 1024;

    // fixed field widths
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int OFFSET_W   = 5;
    localparam int INDEX_W    = 4;
    localparam int WAYS_CFG_W = 4;
    localparam int WAYS_EFF_W = 5;
    localparam int WAY_OUT_W  = 3;
    localparam int CNT_W      = 32;

    // extracted index before the modulo: index_bits reaches 15
    localparam int IDX_W   = 15;
    // reciprocal modulo: k = 32 is exact for IDX_W + log2(sets) <= 32
    localparam int RECIP_K = 32;
    localparam int RECIP_W = RECIP_K + 1;
    localparam int PROD_W  = IDX_W + RECIP_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

endpackage

>>> hw/rtl/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/sacl_set_map.sv
// ----------------------------------------------------------------------------
// sacl_set_map
// splits an address into tag and set, set reduced modulo the built set count
// ----------------------------------------------------------------------------
module sacl_set_map #(
    parameter int SETS = sacl_pkg::SETS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    load,
    input  logic [sacl_pkg::ADDR_W-1:0]             address,
    input  logic [sacl_pkg::OFFSET_W-1:0]           offset_bits,
    input  logic [sacl_pkg::INDEX_W-1:0]            index_bits,
    output logic [sacl_pkg::TAG_W-1:0]              tag,
    output logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] set_idx
);

    localparam int SETW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam logic [sacl_pkg::RECIP_W-1:0] MOD_RECIP =
        sacl_pkg::RECIP_W'(((64'd1 << sacl_pkg::RECIP_K) + 64'(SETS) - 64'd1) / 64'(SETS));

    logic [sacl_pkg::ADDR_W-1:0] shifted;
    logic [5:0]                  tag_shift;
    logic [sacl_pkg::IDX_W-1:0]  idx_next;
    logic [sacl_pkg::IDX_W-1:0]  idx_reg;
    logic [sacl_pkg::TAG_W-1:0]  tag_reg;
    logic [sacl_pkg::PROD_W-1:0] prod;
    logic [sacl_pkg::IDX_W-1:0]  quot_reg;
    logic [31:0]                 rem;

    // shift by 32 or more leaves a zero tag
    assign shifted   = address >> offset_bits;
    assign tag_shift = 6'(offset_bits) + 6'(index_bits);
    assign idx_next  = shifted[sacl_pkg::IDX_W-1:0]
                     & ~({sacl_pkg::IDX_W{1'b1}} << index_bits);

    always_ff @(posedge aclk) begin
        if (load) begin
            idx_reg <= idx_next;
            tag_reg <= address >> tag_shift;
        end
        quot_reg <= prod[sacl_pkg::RECIP_K +: sacl_pkg::IDX_W];
    end

    assign prod    = sacl_pkg::PROD_W'(idx_reg) * sacl_pkg::PROD_W'(MOD_RECIP);
    assign rem     = 32'(idx_reg) - 32'(quot_reg) * 32'(SETS);
    assign set_idx = rem[SETW-1:0];
    assign tag     = tag_reg;

endmodule

>>> hw/rtl/sacl_way_update.sv
// ----------------------------------------------------------------------------
// sacl_way_update
// tag compare, lru victim pick and recency promotion for one set
// ----------------------------------------------------------------------------
module sacl_way_update #(
    parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF
) (
    input  logic [MAX_WAYS*sacl_pkg::TAG_W-1:0]                       tag_word,
    input  logic [MAX_WAYS*(1+(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1))-1:0] meta,
    input  logic [sacl_pkg::TAG_W-1:0]                                tag,
    input  logic [sacl_pkg::WAYS_EFF_W-1:0]                           ways,
    output logic                                                      hit,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0]          way,
    output logic [MAX_WAYS*sacl_pkg::TAG_W-1:0]                       tag_word_new,
    output logic [MAX_WAYS*(1+(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1))-1:0] meta_new
);

    localparam int WAYW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [WAYW-1:0] order [MAX_WAYS];
    logic [WAYW-1:0] order_new [MAX_WAYS];
    logic [WAYW-1:0] hit_way;
    logic [WAYW-1:0] victim;
    logic [WAYW-1:0] pos;
    logic [MAX_WAYS-1:0] valid;

    // meta word: valid bits low, recency list above, lru first
    always_comb begin
        valid = meta[MAX_WAYS-1:0];
        for (int k = 0; k < MAX_WAYS; k++) begin
            order[k] = meta[MAX_WAYS + k*WAYW +: WAYW];
        end
    end

    // lowest matching way wins
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int k = MAX_WAYS - 1; k >= 0; k--) begin
            if (sacl_pkg::WAYS_EFF_W'(k) < ways && valid[k]
                && tag_word[k*sacl_pkg::TAG_W +: sacl_pkg::TAG_W] == tag) begin
                hit     = 1'b1;
                hit_way = WAYW'(k);
            end
        end
    end

    // first list entry among the ways in use
    always_comb begin
        victim = '0;
        for (int p = MAX_WAYS - 1; p >= 0; p--) begin
            if (sacl_pkg::WAYS_EFF_W'(order[p]) < ways) begin
                victim = order[p];
            end
        end
    end

    assign way = hit ? hit_way : victim;

    // move the used way to the mru end of the full list
    always_comb begin
        pos = '0;
        for (int p = MAX_WAYS - 1; p >= 0; p--) begin
            if (order[p] == way) begin
                pos = WAYW'(p);
            end
        end
        for (int k = 0; k < MAX_WAYS - 1; k++) begin
            order_new[k] = (WAYW'(k) < pos) ? order[k] : order[k+1];
        end
        order_new[MAX_WAYS-1] = way;
    end

    always_comb begin
        for (int k = 0; k < MAX_WAYS; k++) begin
            meta_new[k] = valid[k] | (!hit && way == WAYW'(k));
            meta_new[MAX_WAYS + k*WAYW +: WAYW] = order_new[k];
            tag_word_new[k*sacl_pkg::TAG_W +: sacl_pkg::TAG_W] =
                (!hit && way == WAYW'(k)) ? tag
                                          : tag_word[k*sacl_pkg::TAG_W +: sacl_pkg::TAG_W];
        end
    end

endmodule

>>> hw/rtl/set_assoc_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// set-associative tag lookup with true lru replacement and hit/miss counters
// ----------------------------------------------------------------------------
// One address per transfer in, one result per transfer out. The address is
// split into a set index (index_bits bits above offset_bits, reduced modulo
// SETS) and a tag (all bits above both). A hit moves the way to the mru end of
// the set's recency list; a miss refills the lru way among the ways in use,
// free ways are not preferred. For each item the address is first split, then
// the reciprocal multiply of the modulo is done, then the tag and recency
// memories are read synchronously, and last the way is compared and picked
// and the set written back. The next address is taken the cycle after the
// write-back, so a new address is not taken before the last one is through;
// a result waiting in the output register holds back only the write-back of
// the following item. After reset a clearing pass writes the recency and valid
// memory of every set; no address is taken until it ends, configuration writes
// are taken throughout.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup #(
    parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
    parameter int SETS     = sacl_pkg::SETS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wen,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // address in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sacl_pkg::ADDR_W-1:0]         s_address,
    // result out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0]      m_way_used,
    output logic [sacl_pkg::CNT_W-1:0]          m_hits_so_far,
    output logic [sacl_pkg::CNT_W-1:0]          m_misses_so_far
);

    localparam int WAYW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SETW   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int META_W = MAX_WAYS * (1 + WAYW);
    localparam int TAGS_W = MAX_WAYS * sacl_pkg::TAG_W;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SET   = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [SETW-1:0] clr_cnt_reg, clr_cnt_next;

    // configuration registers
    logic [sacl_pkg::OFFSET_W-1:0]   offset_bits_reg;
    logic [sacl_pkg::INDEX_W-1:0]    index_bits_reg;
    logic [sacl_pkg::WAYS_CFG_W-1:0] ways_in_use_reg;
    logic [sacl_pkg::WAYS_EFF_W-1:0] ways_eff;

    // counters and output register
    logic [sacl_pkg::CNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [sacl_pkg::CNT_W-1:0] miss_cnt_reg, miss_cnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       m_hit_reg;
    logic [WAYW-1:0]            m_way_reg;

    // datapath
    logic                       s_xfer;
    logic                       load_result;
    logic [sacl_pkg::TAG_W-1:0] tag;
    logic [SETW-1:0]            set_idx;
    logic [SETW-1:0]            set_reg;
    logic [TAGS_W-1:0]          tags_rd, tags_new;
    logic [META_W-1:0]          meta_rd, meta_new, meta_init, meta_wdata;
    logic [SETW-1:0]            meta_waddr;
    logic                       meta_we;
    logic                       rd_en;
    logic                       hit;
    logic [WAYW-1:0]            way;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_xfer      = s_valid && s_ready;
    // write-back waits for a free output register
    assign load_result = (state_reg == ST_EVAL) && (!m_valid_reg || m_ready);
    assign rd_en       = (state_reg == ST_SET);

    // ways_in_use of zero acts as one, above the build acts as the build
    always_comb begin
        if (ways_in_use_reg == '0) begin
            ways_eff = sacl_pkg::WAYS_EFF_W'(1);
        end else if (sacl_pkg::WAYS_EFF_W'(ways_in_use_reg)
                     > sacl_pkg::WAYS_EFF_W'(MAX_WAYS)) begin
            ways_eff = sacl_pkg::WAYS_EFF_W'(MAX_WAYS);
        end else begin
            ways_eff = sacl_pkg::WAYS_EFF_W'(ways_in_use_reg);
        end
    end

    // configuration writes, unknown index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= '0;
            index_bits_reg  <= '0;
            ways_in_use_reg <= sacl_pkg::WAYS_CFG_W'(1);
        end else if (cfg_wen) begin
            case (cfg_index)
                sacl_pkg::CFG_OFFSET_BITS: begin
                    offset_bits_reg <= cfg_wdata;
                end
                sacl_pkg::CFG_INDEX_BITS: begin
                    index_bits_reg <= cfg_wdata[sacl_pkg::INDEX_W-1:0];
                end
                sacl_pkg::CFG_WAYS_IN_USE: begin
                    ways_in_use_reg <= cfg_wdata[sacl_pkg::WAYS_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // address split and set modulo
    sacl_set_map #(
        .SETS (SETS)
    ) u_set_map (
        .aclk        (aclk),
        .load        (s_xfer),
        .address     (s_address),
        .offset_bits (offset_bits_reg),
        .index_bits  (index_bits_reg),
        .tag         (tag),
        .set_idx     (set_idx)
    );

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            set_reg <= set_idx;
        end
    end

    // reset image of one set: nothing valid, ways in ascending order
    always_comb begin
        meta_init = '0;
        for (int k = 0; k < MAX_WAYS; k++) begin
            meta_init[MAX_WAYS + k*WAYW +: WAYW] = WAYW'(k);
        end
    end

    // meta memory is written by the clearing pass and by the write-back
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            meta_we    = 1'b1;
            meta_waddr = clr_cnt_reg;
            meta_wdata = meta_init;
        end else begin
            meta_we    = load_result;
            meta_waddr = set_reg;
            meta_wdata = meta_new;
        end
    end

    // tags of one set, one word per set, no reset image
    sacl_ram #(
        .WIDTH (TAGS_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (load_result && !hit),
        .waddr (set_reg),
        .wdata (tags_new),
        .re    (rd_en),
        .raddr (set_idx),
        .rdata (tags_rd)
    );

    // valid bits and recency list of one set
    sacl_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (rd_en),
        .raddr (set_idx),
        .rdata (meta_rd)
    );

    // compare, victim pick and promotion on the read set
    sacl_way_update #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_update (
        .tag_word     (tags_rd),
        .meta         (meta_rd),
        .tag          (tag),
        .ways         (ways_eff),
        .hit          (hit),
        .way          (way),
        .tag_word_new (tags_new),
        .meta_new     (meta_new)
    );

    // sequencer: one set read-modify-write at a time, so no same-set overlap
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + SETW'(1);
                if (clr_cnt_reg == SETW'(SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                state_next = ST_SET;
            end
            ST_SET: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (load_result) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // counters and output handshake
    always_comb begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_result) begin
            m_valid_next = 1'b1;
            if (hit) begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end else begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            m_hit_reg <= hit;
            m_way_reg <= way;
        end
    end

    // counters only move at write-back, so they hold while a result waits
    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_way_used      = sacl_pkg::WAY_OUT_W'(m_way_reg);
    assign m_hits_so_far   = hit_cnt_reg;
    assign m_misses_so_far = miss_cnt_reg;

`ifndef SYNTHESIS
    // an accepted address reaches write-back after the split, modulo and read
    a_eval_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |-> ##3 (state_reg == ST_EVAL))
        else $error("accepted address did not reach write-back in time");

    // each write-back bumps exactly one of the two counters
    a_one_count: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |=> (hit_cnt_reg + miss_cnt_reg
                         == $past(hit_cnt_reg) + $past(miss_cnt_reg) + 1'b1))
        else $error("counters did not advance by one on write-back");

    // a refill always lands on a way in use
    a_refill_way: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_result && !hit) |-> (sacl_pkg::WAYS_EFF_W'(way) < ways_eff))
        else $error("refill picked a way outside the ways in use");

    // write-back never overwrites an unread result
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while waiting");
`endif

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the set-associative lru lookup
// ----------------------------------------------------------------------------
// Addresses go in over a valid/ready channel, one result per address comes
// back. A local mirror of the tag, valid and recency state predicts hit, way
// and the running hit and miss totals for every accepted address. A short
// table of directed rows covers the reset config, the ways clamps, wide and
// out-of-range splits and an ignored register write. Randomized phases then
// follow, each with its own split and associativity, mostly hammering a small
// pool of addresses that collide in a few sets.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // widths and register codes taken from the shared package
    localparam int ADDR_W     = sacl_pkg::ADDR_W;
    localparam int TAG_W      = sacl_pkg::TAG_W;
    localparam int WAY_OUT_W  = sacl_pkg::WAY_OUT_W;
    localparam int CNT_W      = sacl_pkg::CNT_W;
    localparam int CFG_IDX_W  = sacl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sacl_pkg::CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = sacl_pkg::CFG_OFFSET_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = sacl_pkg::CFG_INDEX_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = sacl_pkg::CFG_WAYS_IN_USE;

    localparam int NUM_WAYS = sacl_pkg::MAX_WAYS_DEF;
    localparam int NUM_SETS = sacl_pkg::SETS_DEF;

    localparam int DIRECTED_ROWS  = 35;
    localparam int RANDOM_LOOKUPS = 1750;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_PRINTED    = 40;

    // register index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     misses;
    } lookup_result_t;

    typedef enum logic {ROW_WRITE, ROW_LOOKUP} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [ADDR_W-1:0]     address;
        bit                    known;
        lookup_result_t        typed;
    } stim_row_t;

    // dut ports, inputs all known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [ADDR_W-1:0]     s_address = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_hit;
    logic [WAY_OUT_W-1:0]  m_way_used;
    logic [CNT_W-1:0]      m_hits_so_far;
    logic [CNT_W-1:0]      m_misses_so_far;

    // mirror of the lookup state
    logic [TAG_W-1:0] tag_mirror   [NUM_SETS][NUM_WAYS];
    bit               valid_mirror [NUM_SETS][NUM_WAYS];
    int unsigned      lru_order    [NUM_SETS][NUM_WAYS];   // index 0 is lru
    logic [4:0]       cfg_offset     = 5'd0;
    logic [3:0]       cfg_index_bits = 4'd0;
    logic [3:0]       cfg_ways       = 4'd1;
    logic [CNT_W-1:0] hit_total      = '0;
    logic [CNT_W-1:0] miss_total     = '0;

    lookup_result_t expected_results [$];
    int             error_count  = 0;
    int             results_seen = 0;
    int             burst_left   = 0;

    // long receiver hold-off, asked by the stimulus and served by the receiver
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;

    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age   = 0;

    // directed rows: typed results only where they are obvious
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // reset config: one way, set 0 only, tag is the whole address
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0000, 1'b1, '{1'b0, 3'd0, 32'd0, 32'd1}},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0000, 1'b1, '{1'b1, 3'd0, 32'd1, 32'd1}},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 32'd1, 32'd2}},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'hFFFF_FFFF, 1'b1, '{1'b1, 3'd0, 32'd2, 32'd2}},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0000, 1'b1, '{1'b0, 3'd0, 32'd2, 32'd3}},
        // zero ways behaves as one way, bit 4 of the data is dropped
        '{ROW_WRITE,  CFG_WAYS_IN_USE, 5'h10, 32'h0000_0000, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0000, 1'b1, '{1'b1, 3'd0, 32'd3, 32'd3}},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0001, 1'b1, '{1'b0, 3'd0, 32'd3, 32'd4}},
        // fifteen ways clamps to the built ways
        '{ROW_WRITE,  CFG_WAYS_IN_USE, 5'h1F, 32'h0000_0000, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0001, 1'b1, '{1'b1, 3'd0, 32'd4, 32'd4}},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0002, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0003, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0001, 1'b0, '0},
        // shrink the ways mid-run, recency among the survivors must hold
        '{ROW_WRITE,  CFG_WAYS_IN_USE, 5'h02, 32'h0000_0000, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0004, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0002, 1'b0, '0},
        // widest split: tag is zero, index bits past bit 31 read as zero
        '{ROW_WRITE,  CFG_OFFSET_BITS, 5'h1F, 32'h0000_0000, 1'b0, '0},
        '{ROW_WRITE,  CFG_INDEX_BITS,  5'h0F, 32'h0000_0000, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h8000_0000, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h7FFF_FFFF, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h8000_0000, 1'b0, '0},
        // index wider than the sets wraps modulo the set count
        '{ROW_WRITE,  CFG_OFFSET_BITS, 5'h00, 32'h0000_0000, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_7FFF, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0400, 1'b0, '0},
        // top of the nominal ranges
        '{ROW_WRITE,  CFG_OFFSET_BITS, 5'h10, 32'h0000_0000, 1'b0, '0},
        '{ROW_WRITE,  CFG_INDEX_BITS,  5'h0A, 32'h0000_0000, 1'b0, '0},
        '{ROW_WRITE,  CFG_WAYS_IN_USE, 5'h08, 32'h0000_0000, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'hFFFF_0000, 1'b0, '0},
        // offset plus index exactly 32
        '{ROW_WRITE,  CFG_OFFSET_BITS, 5'h11, 32'h0000_0000, 1'b0, '0},
        '{ROW_WRITE,  CFG_INDEX_BITS,  5'h0F, 32'h0000_0000, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'hFFFE_0000, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'h0000_0000, 1'b0, '0},
        // write to an unmapped index changes nothing
        '{ROW_WRITE,  CFG_UNMAPPED,    5'h15, 32'h0000_0000, 1'b0, '0},
        '{ROW_LOOKUP, CFG_OFFSET_BITS, 5'h00, 32'hFFFE_0000, 1'b0, '0}
    };

    set_assoc_cache_lru_lookup u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_address       (s_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_way_used      (m_way_used),
        .m_hits_so_far   (m_hits_so_far),
        .m_misses_so_far (m_misses_so_far)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_problem(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("[%0t] %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_OFFSET_BITS: cfg_offset     = data[4:0];
            CFG_INDEX_BITS:  cfg_index_bits = data[3:0];
            CFG_WAYS_IN_USE: cfg_ways       = data[3:0];
            default: ;
        endcase
    endfunction

    // one lookup against the mirror, updates tags, valid marks, recency, totals
    function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
        logic [63:0]      idx_wide;
        logic [TAG_W-1:0] tag;
        int unsigned      set_no;
        int unsigned      shift;
        int unsigned      ways_eff;
        int unsigned      way;
        int unsigned      pos;
        int unsigned      k;
        bit               found;
        lookup_result_t   res;
        shift    = int'(cfg_offset) + int'(cfg_index_bits);
        idx_wide = ({32'd0, addr} >> cfg_offset) & ((64'd1 << cfg_index_bits) - 64'd1);
        set_no   = int'(idx_wide % NUM_SETS);
        tag      = (shift >= 32) ? '0 : addr >> shift;
        ways_eff = (cfg_ways == 0) ? 1 : ((cfg_ways > NUM_WAYS) ? NUM_WAYS : cfg_ways);
        found    = 1'b0;
        way      = 0;
        for (k = 0; k < ways_eff; k++) begin
            if (!found && valid_mirror[set_no][k] && tag_mirror[set_no][k] == tag) begin
                found = 1'b1;
                way   = k;
            end
        end
        if (found) begin
            hit_total++;
        end else begin
            miss_total++;
            // oldest way in use gets the refill, free ways get no priority
            for (k = 0; k < NUM_WAYS; k++) begin
                if (lru_order[set_no][k] < ways_eff) begin
                    way = lru_order[set_no][k];
                    break;
                end
            end
            tag_mirror[set_no][way]   = tag;
            valid_mirror[set_no][way] = 1'b1;
        end
        // move the used way to the mru end of the full list
        pos = 0;
        while (lru_order[set_no][pos] != way) pos++;
        for (k = pos; k + 1 < NUM_WAYS; k++) begin
            lru_order[set_no][k] = lru_order[set_no][k + 1];
        end
        lru_order[set_no][NUM_WAYS - 1] = way;
        res.hit    = found;
        res.way    = way[WAY_OUT_W-1:0];
        res.hits   = hit_total;
        res.misses = miss_total;
        return res;
    endfunction

    // offer one address in bursts with random gaps, predict on the transfer
    task automatic send_lookup(input logic [ADDR_W-1:0] addr, input bit known,
                               input lookup_result_t typed);
        lookup_result_t predicted;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_address <= addr;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_lookup(addr);
        expected_results.push_back(known ? typed : predicted);
    endtask

    // drop valid and let every outstanding result drain before a register write
    task automatic quiesce();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        apply_register(idx, data);
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver: rotating stall pattern, reloaded now and then, plus a long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            m_ready      <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            m_ready <= stall_pattern[0];
            if (pattern_age == 63) begin
                pattern_age <= 0;
                case ($urandom_range(0, 3))
                    0: stall_pattern <= 16'hFFFF;
                    1: stall_pattern <= 16'($urandom);
                    2: stall_pattern <= 16'($urandom | $urandom);
                    default: stall_pattern <= 16'($urandom & $urandom) | 16'h0001;
                endcase
            end else begin
                pattern_age   <= pattern_age + 1;
                stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // result checker, compares each transfer with the oldest prediction
    always @(posedge aclk) begin : result_check
        lookup_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_problem($sformatf("result %0d arrived with no lookup outstanding",
                                         results_seen));
            end else begin
                want = expected_results.pop_front();
                if (m_hit !== want.hit)
                    report_problem($sformatf("result %0d hit: expected %0d, got %0d",
                                             results_seen, want.hit, m_hit));
                if (m_way_used !== want.way)
                    report_problem($sformatf("result %0d way: expected %0d, got %0d",
                                             results_seen, want.way, m_way_used));
                if (m_hits_so_far !== want.hits)
                    report_problem($sformatf("result %0d hits: expected %0d, got %0d",
                                             results_seen, want.hits, m_hits_so_far));
                if (m_misses_so_far !== want.misses)
                    report_problem($sformatf("result %0d misses: expected %0d, got %0d",
                                             results_seen, want.misses, m_misses_so_far));
            end
        end
    end

    // stimulus
    initial begin
        logic [ADDR_W-1:0] addr_pool [$];
        logic [31:0]       set_choices [4];
        logic [63:0]       wide;
        logic [63:0]       idx_mask;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] low_mask;
        int                ph_off;
        int                ph_idx;
        int                ph_ways;
        int                shift;
        int                n_sets;
        int                phase_len;
        int                phase;
        int                random_sent;
        int                i;
        int                n;

        for (i = 0; i < NUM_SETS; i++) begin
            for (n = 0; n < NUM_WAYS; n++) begin
                valid_mirror[i][n] = 1'b0;
                lru_order[i][n]    = n;
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table; the clearing pass after reset just holds off s_ready
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                quiesce();
                write_register(directed_rows[r].reg_idx, directed_rows[r].reg_data);
            end else begin
                send_lookup(directed_rows[r].address, directed_rows[r].known,
                            directed_rows[r].typed);
            end
        end

        // randomized phases, each with its own split and associativity
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_LOOKUPS) begin
            quiesce();
            case (phase)
                0: begin ph_off = 0;  ph_idx = 0;  ph_ways = 1;  end
                1: begin ph_off = 16; ph_idx = 10; ph_ways = 8;  end
                2: begin ph_off = 31; ph_idx = 15; ph_ways = 15; end
                3: begin ph_off = 0;  ph_idx = 15; ph_ways = 0;  end
                default: begin
                    ph_off  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 16)
                                                         : $urandom_range(17, 31);
                    ph_idx  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 10)
                                                         : $urandom_range(11, 15);
                    ph_ways = $urandom_range(0, 15);
                end
            endcase
            // bit 4 of the data is don't-care for the narrower registers
            write_register(CFG_OFFSET_BITS, 5'(ph_off));
            write_register(CFG_INDEX_BITS,  5'(ph_idx)  | (5'($urandom_range(0, 1)) << 4));
            write_register(CFG_WAYS_IN_USE, 5'(ph_ways) | (5'($urandom_range(0, 1)) << 4));

            // small pool of addresses crowded into a few sets to drive lru turnover
            shift    = ph_off + ph_idx;
            idx_mask = (64'd1 << ph_idx) - 64'd1;
            n_sets   = $urandom_range(1, 4);
            for (i = 0; i < 4; i++) set_choices[i] = $urandom;
            addr_pool.delete();
            n = $urandom_range(1, 19);
            for (i = 0; i < n; i++) begin
                wide = (64'($urandom) << shift)
                     | ((64'(set_choices[$urandom_range(0, n_sets - 1)]) & idx_mask) << ph_off);
                addr_pool.push_back(wide[ADDR_W-1:0]);
            end
            low_mask = ADDR_W'((64'd1 << ph_off) - 64'd1);

            phase_len = $urandom_range(60, 180);
            for (n = 0; n < phase_len && random_sent < RANDOM_LOOKUPS; n++) begin
                // long receiver hold while addresses keep coming, fills the pipe
                if (phase == 1 && n == 20) holds_asked <= holds_asked + 1;
                if ($urandom_range(0, 99) < 75) begin
                    addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
                    addr = (addr & ~low_mask) | ($urandom & low_mask);
                end else begin
                    addr = $urandom;
                end
                send_lookup(addr, 1'b0, '0);
                random_sent++;
            end
            phase++;
        end

        // drain and give stray results a chance to show up
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
